// ===== hw/rtl/rtsk_pkg.sv =====
package rtsk_pkg;

  localparam int unsigned TAGS_DEF = 64;
  localparam int unsigned Q_DEPTH  = 2;

  typedef enum logic [1:0] {
    ACT_OBSERVE = 2'd0,
    ACT_SET_POS = 2'd1,
    ACT_REPORT  = 2'd2,
    ACT_LOCATE  = 2'd3
  } action_e;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;

  localparam logic [1:0] REG_NEIGHBOUR_COUNT = 2'd0;
  localparam logic [1:0] REG_TARGET_TAG      = 2'd1;

  localparam int unsigned DIV_NUM_W = 41;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_QUO_W = 27;
  localparam int unsigned DIV_TOP_W = 5;

  typedef struct packed {
    action_e            action;
    logic [5:0]         tag_index;
    logic signed [7:0]  rssi;
    logic [26:0]        time_ms;
    logic [7:0]         pos_x;
    logic [7:0]         pos_y;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] avg_rssi;
    logic signed [7:0]  min_rssi;
    logic signed [7:0]  max_rssi;
    logic [26:0]        avg_interval_ms;
    logic [15:0]        sighting_count;
    logic [7:0]         est_x;
    logic [7:0]         est_y;
    logic [5:0]         neighbours_used;
  } res_t;

  typedef struct packed {
    logic [5:0] neighbour_count;
    logic [5:0] target_tag;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_TOP_W-1:0] top;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

// ===== hw/rtl/rtsk_fifo.sv =====
module rtsk_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = rtsk_pkg::Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import rtsk_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rtsk_div.sv =====
module rtsk_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtsk_pkg::div_req_t req_i,
  output rtsk_pkg::div_rsp_t rsp_o
);
  import rtsk_pkg::*;

  localparam int unsigned DS_W = DIV_DEN_W + DIV_QUO_W - 1;

  logic                 busy_q, done_q;
  logic [DIV_TOP_W-1:0] step_q;
  logic [DIV_NUM_W-1:0] rem_q;
  logic [DS_W-1:0]      ds_q;
  logic [DIV_QUO_W-1:0] quo_q;
  logic                 ge;

  // restoring step: one quotient bit per cycle, from bit top down to bit 0
  assign ge = {{(DS_W-DIV_NUM_W){1'b0}}, rem_q} >= ds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      ds_q   <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.num;
        ds_q   <= DS_W'(req_i.den) << req_i.top;
        step_q <= req_i.top;
        quo_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= rem_q - ds_q[DIV_NUM_W-1:0];
        end
        quo_q <= {quo_q[DIV_QUO_W-2:0], ge};
        ds_q  <= ds_q >> 1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quo    = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ===== hw/rtl/rtsk_engine.sv =====
module rtsk_engine #(
  parameter int unsigned TAGS = rtsk_pkg::TAGS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtsk_pkg::cfg_t     cfg_i,
  input  logic               cmd_empty_i,
  input  rtsk_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output rtsk_pkg::res_t     res_o,
  output rtsk_pkg::div_req_t div_req_o,
  input  rtsk_pkg::div_rsp_t div_rsp_i
);
  import rtsk_pkg::*;

  localparam int unsigned AW = (TAGS > 1) ? $clog2(TAGS) : 1;
  localparam logic [AW-1:0] LAST = AW'(TAGS - 1);

  typedef struct packed {
    logic [15:0]        cnt;
    logic signed [23:0] sum;
    logic signed [7:0]  low;
    logic signed [7:0]  high;
    logic [26:0]        first;
    logic [26:0]        last;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_OWAIT, S_OUPD, S_PWR, S_RWAIT, S_RCHK, S_RAVG, S_RINT,
    S_TWAIT, S_TCHK, S_DWAIT, S_DCHK, S_DMUL, S_DSUB, S_DDIV,
    S_SWAIT, S_SCMP, S_CWAIT, S_CACC, S_AVGX, S_XDIV, S_YDIV, S_PUSH
  } state_e;

  state_e             state_q;
  cmd_t               cmd_q;
  logic [AW-1:0]      addr_q, tgt_q, best_q;
  logic               oor_q, have_q;
  stat_t              ent_q;
  logic signed [23:0] ts_q, sj_q;
  logic [15:0]        tc_q, cj_q;
  logic signed [40:0] pa_q, pb_q;
  logic [31:0]        den_q;
  logic [7:0]         best_d_q;
  logic [13:0]        sx_q, sy_q;
  logic [5:0]         used_q;
  res_t               res_q;
  div_req_t           div_q;
  logic [TAGS-1:0]    cand_q, stat_vld_q, pos_vld_q;

  stat_t       stat_mem [TAGS];
  logic [15:0] coord_mem [TAGS];
  logic [7:0]  dist_mem [TAGS];
  stat_t       stat_rd_q;
  logic [15:0] coord_rd_q;
  logic [7:0]  dist_rd_q;
  logic        stat_rvld_q, pos_rvld_q;

  stat_t              upd;
  logic               stat_we, coord_we, dist_we;
  logic signed [40:0] mul_a, mul_b;
  logic signed [41:0] diff;
  logic [40:0]        diff_mag;
  logic [31:0]        avg_num;
  logic [16:0]        avg_q17;
  logic [6:0]         used_inc;
  logic [7:0]         x_add, y_add;

  always_comb begin
    upd = stat_rd_q;
    if (!stat_rvld_q) begin
      upd.cnt   = 16'd1;
      upd.sum   = {{16{cmd_q.rssi[7]}}, cmd_q.rssi};
      upd.low   = cmd_q.rssi;
      upd.high  = cmd_q.rssi;
      upd.first = cmd_q.time_ms;
    end else begin
      upd.cnt  = stat_rd_q.cnt + 16'd1;
      upd.sum  = stat_rd_q.sum + {{16{cmd_q.rssi[7]}}, cmd_q.rssi};
      upd.low  = ($signed(cmd_q.rssi) < $signed(stat_rd_q.low)) ? cmd_q.rssi : stat_rd_q.low;
      upd.high = ($signed(cmd_q.rssi) > $signed(stat_rd_q.high)) ? cmd_q.rssi : stat_rd_q.high;
    end
    upd.last = cmd_q.time_ms;
  end

  // a saturated count freezes the entry
  assign stat_we  = (state_q == S_OUPD) && !oor_q &&
                    !(stat_rvld_q && (stat_rd_q.cnt == 16'hFFFF));
  assign coord_we = (state_q == S_PWR) && !oor_q;
  assign dist_we  = (state_q == S_DDIV) && div_rsp_i.done;

  assign mul_a    = ts_q * $signed({1'b0, cj_q});
  assign mul_b    = sj_q * $signed({1'b0, tc_q});
  assign diff     = 42'(pa_q) - 42'(pb_q);
  assign diff_mag = diff[41] ? 41'(-diff) : 41'(diff);
  assign avg_num  = stat_rd_q.sum[23] ? (32'd0 - {stat_rd_q.sum, 8'd0}) :
                    {stat_rd_q.sum, 8'd0};
  assign avg_q17  = {1'b0, div_rsp_i.quo[15:0]} + {16'd0, div_rsp_i.rem_nz};
  assign used_inc = {1'b0, used_q} + 7'd1;
  assign x_add    = pos_rvld_q ? coord_rd_q[15:8] : 8'd0;
  assign y_add    = pos_rvld_q ? coord_rd_q[7:0] : 8'd0;

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[addr_q] <= upd;
    end
    if (coord_we) begin
      coord_mem[addr_q] <= {cmd_q.pos_x, cmd_q.pos_y};
    end
    if (dist_we) begin
      dist_mem[addr_q] <= div_rsp_i.quo[7:0];
    end
    stat_rd_q  <= stat_mem[addr_q];
    coord_rd_q <= coord_mem[addr_q];
    dist_rd_q  <= dist_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_rvld_q <= 1'b0;
      pos_rvld_q  <= 1'b0;
    end else begin
      stat_rvld_q <= stat_vld_q[addr_q];
      pos_rvld_q  <= pos_vld_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= '0;
      addr_q     <= '0;
      tgt_q      <= '0;
      best_q     <= '0;
      oor_q      <= 1'b0;
      have_q     <= 1'b0;
      ent_q      <= '0;
      ts_q       <= '0;
      tc_q       <= '0;
      sj_q       <= '0;
      cj_q       <= '0;
      pa_q       <= '0;
      pb_q       <= '0;
      den_q      <= '0;
      best_d_q   <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      used_q     <= '0;
      res_q      <= '0;
      div_q      <= '0;
      cand_q     <= '0;
      stat_vld_q <= '0;
      pos_vld_q  <= '0;
    end else begin
      div_q.start <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q <= cmd_i;
            res_q <= '0;
            if (cmd_i.action == ACT_LOCATE) begin
              addr_q     <= AW'(cfg_i.target_tag);
              tgt_q      <= AW'(cfg_i.target_tag);
              oor_q      <= (int'(cfg_i.target_tag) >= TAGS);
              res_q.kind <= KIND_LOCATE;
              state_q    <= S_TWAIT;
            end else begin
              addr_q     <= AW'(cmd_i.tag_index);
              oor_q      <= (int'(cmd_i.tag_index) >= TAGS);
              res_q.kind <= KIND_REPORT;
              case (cmd_i.action)
                ACT_OBSERVE: state_q <= S_OWAIT;
                ACT_SET_POS: state_q <= S_PWR;
                default:     state_q <= S_RWAIT;
              endcase
            end
          end
        end
        S_OWAIT: state_q <= S_OUPD;
        S_OUPD: begin
          if (stat_we) begin
            stat_vld_q[addr_q] <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_PWR: begin
          if (coord_we) begin
            pos_vld_q[addr_q] <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_RWAIT: state_q <= S_RCHK;
        S_RCHK: begin
          if (oor_q || !stat_rvld_q) begin
            state_q <= S_PUSH;
          end else begin
            ent_q                <= stat_rd_q;
            res_q.sighting_count <= stat_rd_q.cnt;
            res_q.min_rssi       <= stat_rd_q.low;
            res_q.max_rssi       <= stat_rd_q.high;
            // launch the average divide on the magnitude of sum*256
            div_q.start          <= 1'b1;
            div_q.num            <= 41'(avg_num);
            div_q.den            <= 32'(stat_rd_q.cnt);
            div_q.top            <= 5'd15;
            state_q              <= S_RAVG;
          end
        end
        S_RAVG: begin
          if (div_rsp_i.done) begin
            res_q.avg_rssi <= ent_q.sum[23] ? 16'(17'd0 - avg_q17) : div_rsp_i.quo[15:0];
            if ((ent_q.cnt >= 16'd2) && (ent_q.last >= ent_q.first)) begin
              div_q.start <= 1'b1;
              div_q.num   <= 41'(ent_q.last - ent_q.first);
              div_q.den   <= 32'(ent_q.cnt - 16'd1);
              div_q.top   <= 5'd26;
              state_q     <= S_RINT;
            end else begin
              state_q <= S_PUSH;
            end
          end
        end
        S_RINT: begin
          if (div_rsp_i.done) begin
            res_q.avg_interval_ms <= div_rsp_i.quo;
            state_q               <= S_PUSH;
          end
        end
        S_TWAIT: state_q <= S_TCHK;
        S_TCHK: begin
          if (oor_q || !stat_rvld_q || (cfg_i.neighbour_count == 6'd0)) begin
            state_q <= S_PUSH;
          end else begin
            ts_q    <= stat_rd_q.sum;
            tc_q    <= stat_rd_q.cnt;
            sx_q    <= '0;
            sy_q    <= '0;
            used_q  <= '0;
            addr_q  <= '0;
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: state_q <= S_DCHK;
        S_DCHK: begin
          if (stat_rvld_q && (addr_q != tgt_q)) begin
            sj_q    <= stat_rd_q.sum;
            cj_q    <= stat_rd_q.cnt;
            state_q <= S_DMUL;
          end else begin
            cand_q[addr_q] <= 1'b0;
            if (addr_q == LAST) begin
              addr_q  <= '0;
              have_q  <= 1'b0;
              state_q <= S_SWAIT;
            end else begin
              addr_q  <= addr_q + 1'b1;
              state_q <= S_DWAIT;
            end
          end
        end
        S_DMUL: begin
          pa_q    <= mul_a;
          pb_q    <= mul_b;
          den_q   <= tc_q * cj_q;
          state_q <= S_DSUB;
        end
        S_DSUB: begin
          // distance never exceeds 255, so nine quotient bits suffice
          div_q.start <= 1'b1;
          div_q.num   <= diff_mag;
          div_q.den   <= den_q;
          div_q.top   <= 5'd8;
          state_q     <= S_DDIV;
        end
        S_DDIV: begin
          if (div_rsp_i.done) begin
            cand_q[addr_q] <= 1'b1;
            if (addr_q == LAST) begin
              addr_q  <= '0;
              have_q  <= 1'b0;
              state_q <= S_SWAIT;
            end else begin
              addr_q  <= addr_q + 1'b1;
              state_q <= S_DWAIT;
            end
          end
        end
        S_SWAIT: state_q <= S_SCMP;
        S_SCMP: begin
          // strict less-than keeps the lowest index on a tie
          if (cand_q[addr_q] && (!have_q || (dist_rd_q < best_d_q))) begin
            have_q   <= 1'b1;
            best_q   <= addr_q;
            best_d_q <= dist_rd_q;
          end
          if (addr_q == LAST) begin
            if (have_q || cand_q[addr_q]) begin
              addr_q  <= (cand_q[addr_q] && (!have_q || (dist_rd_q < best_d_q))) ?
                         addr_q : best_q;
              state_q <= S_CWAIT;
            end else begin
              state_q <= S_AVGX;
            end
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= S_SWAIT;
          end
        end
        S_CWAIT: state_q <= S_CACC;
        S_CACC: begin
          cand_q[addr_q] <= 1'b0;
          sx_q           <= sx_q + 14'(x_add);
          sy_q           <= sy_q + 14'(y_add);
          used_q         <= used_inc[5:0];
          if (used_inc[5:0] == cfg_i.neighbour_count) begin
            state_q <= S_AVGX;
          end else begin
            addr_q  <= '0;
            have_q  <= 1'b0;
            state_q <= S_SWAIT;
          end
        end
        S_AVGX: begin
          if (used_q == '0) begin
            state_q <= S_PUSH;
          end else begin
            div_q.start <= 1'b1;
            div_q.num   <= 41'(sx_q);
            div_q.den   <= 32'(used_q);
            div_q.top   <= 5'd7;
            state_q     <= S_XDIV;
          end
        end
        S_XDIV: begin
          if (div_rsp_i.done) begin
            res_q.est_x <= div_rsp_i.quo[7:0];
            div_q.start <= 1'b1;
            div_q.num   <= 41'(sy_q);
            div_q.den   <= 32'(used_q);
            div_q.top   <= 5'd7;
            state_q     <= S_YDIV;
          end
        end
        S_YDIV: begin
          if (div_rsp_i.done) begin
            res_q.est_y           <= div_rsp_i.quo[7:0];
            res_q.neighbours_used <= used_q;
            state_q               <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign res_push_o = (state_q == S_PUSH) && !res_full_i;
  assign res_o      = res_q;
  assign div_req_o  = div_q;

endmodule

// ===== hw/rtl/rssi_tag_stats_knn_locator.sv =====
// RSSI tag statistics table with a k-nearest-neighbour locator. Requests enter
// a two-deep command queue (push/full) and results leave through a two-deep
// result queue (empty/pop), so a short stall on either side need not hold up
// the other. An observe request folds one sighting into a table entry and a
// set_position request loads coordinates. A report request takes one serial
// divide for the average (16 steps) and, with two or more sightings and a last
// time not before the first, one for the interval (27 steps). A locate request
// makes one distance pass over the table, with a 9-step divide for each other
// seen tag, then one selection pass per neighbour picked, ending with two 8-step
// divides for the coordinate means. All divides run on the single bit-per-cycle
// divider, and the table memories have a single read port. Configuration
// writes take effect at once and must only be issued while the block is idle.
module rssi_tag_stats_knn_locator #(
  parameter int unsigned TAGS = rtsk_pkg::TAGS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [5:0]  tag_index_i,
  input  logic [7:0]  rssi_i,
  input  logic [26:0] time_ms_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [15:0] avg_rssi_o,
  output logic [7:0]  min_rssi_o,
  output logic [7:0]  max_rssi_o,
  output logic [26:0] avg_interval_ms_o,
  output logic [15:0] sighting_count_o,
  output logic [7:0]  est_x_o,
  output logic [7:0]  est_y_o,
  output logic [5:0]  neighbours_used_o
);
  import rtsk_pkg::*;

  cfg_t     cfg_q;
  cmd_t     cmd_in, cmd_head;
  res_t     res_eng, res_head;
  logic     cmd_empty, cmd_pop, res_full, res_push;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // register file: unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neighbour_count <= 6'd4;
      cfg_q.target_tag      <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEIGHBOUR_COUNT: cfg_q.neighbour_count <= cfg_wdata_i;
        REG_TARGET_TAG:      cfg_q.target_tag      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_in.action    = action_e'(action_i);
    cmd_in.tag_index = tag_index_i;
    cmd_in.rssi      = rssi_i;
    cmd_in.time_ms   = time_ms_i;
    cmd_in.pos_x     = pos_x_i;
    cmd_in.pos_y     = pos_y_i;
  end

  // front: hold accepted requests until the engine is free
  rtsk_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(Q_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_head),
    .empty_o(cmd_empty)
  );

  // back: table, distance scan and selection sequencer
  rtsk_engine #(
    .TAGS(TAGS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_empty_i(cmd_empty),
    .cmd_i      (cmd_head),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_eng),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp)
  );

  // shared serial divider for averages, intervals and distances
  rtsk_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // hold finished results until the consumer pops them
  rtsk_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_eng),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign kind_o            = res_head.kind;
  assign avg_rssi_o        = res_head.avg_rssi;
  assign min_rssi_o        = res_head.min_rssi;
  assign max_rssi_o        = res_head.max_rssi;
  assign avg_interval_ms_o = res_head.avg_interval_ms;
  assign sighting_count_o  = res_head.sighting_count;
  assign est_x_o           = res_head.est_x;
  assign est_y_o           = res_head.est_y;
  assign neighbours_used_o = res_head.neighbours_used;

endmodule

// ===== tb/sv/rssi_tag_stats_knn_locator_test.sv =====
`timescale 1ns / 100ps

module rssi_tag_stats_knn_locator_test;
  import rtsk_pkg::*;

  localparam int NTAG = 64;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int MAX_TIME = 86399999;

  // Table mirror and expected-result store for the block.
  class locator_scoreboard;
    int unsigned nbr_count;
    int unsigned target;
    int unsigned hits[NTAG];
    int          sum[NTAG];
    int          low[NTAG];
    int          high[NTAG];
    int unsigned first_ms[NTAG];
    int unsigned last_ms[NTAG];
    int unsigned cx[NTAG];
    int unsigned cy[NTAG];
    res_t        results_due[$];
    int          errors;

    function new();
      nbr_count = 4;
      target = 0;
      errors = 0;
      for (int i = 0; i < NTAG; i++) begin
        hits[i] = 0;
        sum[i] = 0;
        low[i] = 127;
        high[i] = -128;
        first_ms[i] = 0;
        last_ms[i] = 0;
        cx[i] = 0;
        cy[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] val);
      if (idx == REG_NEIGHBOUR_COUNT) nbr_count = val;
      else if (idx == REG_TARGET_TAG) target = val;
    endfunction

    function res_t report_of(int unsigned idx);
      res_t r;
      longint num;
      longint c;
      r = '0;
      r.kind = KIND_REPORT;
      c = hits[idx];
      r.sighting_count = c;
      if (c == 0) return r;
      num = longint'(sum[idx]) * 256;
      if (num >= 0) r.avg_rssi = num / c;
      else r.avg_rssi = -((-num + c - 1) / c);
      r.min_rssi = low[idx];
      r.max_rssi = high[idx];
      if (c >= 2 && last_ms[idx] >= first_ms[idx])
        r.avg_interval_ms = (last_ms[idx] - first_ms[idx]) / (c - 1);
      return r;
    endfunction

    function res_t locate_now();
      res_t r;
      bit picked[NTAG];
      int unsigned used;
      int unsigned sx;
      int unsigned sy;
      longint ts;
      longint tc;
      longint num;
      longint den;
      longint gap_d;
      longint best_d;
      int best;
      r = '0;
      r.kind = KIND_LOCATE;
      used = 0;
      sx = 0;
      sy = 0;
      foreach (picked[i]) picked[i] = 0;
      if (hits[target] == 0) return r;
      ts = sum[target];
      tc = hits[target];
      for (int k = 0; k < nbr_count; k++) begin
        best = -1;
        best_d = 0;
        for (int j = 0; j < NTAG; j++) begin
          if (j == target || picked[j] || hits[j] == 0) continue;
          num = ts * longint'(hits[j]) - longint'(sum[j]) * tc;
          den = tc * longint'(hits[j]);
          if (num < 0) num = -num;
          gap_d = num / den;
          if (best < 0 || gap_d < best_d) begin
            best = j;
            best_d = gap_d;
          end
        end
        if (best < 0) break;
        picked[best] = 1;
        sx += cx[best];
        sy += cy[best];
        used++;
      end
      if (used == 0) return r;
      r.est_x = sx / used;
      r.est_y = sy / used;
      r.neighbours_used = used;
      return r;
    endfunction

    // Fold one accepted request into the mirror and queue its result, if any.
    function void note(action_e act, logic [5:0] idx, logic signed [7:0] rssi,
                       logic [26:0] t, logic [7:0] x, logic [7:0] y);
      case (act)
        ACT_OBSERVE: begin
          if (hits[idx] < 65535) begin
            if (hits[idx] == 0) first_ms[idx] = t;
            last_ms[idx] = t;
            if (int'(rssi) < low[idx]) low[idx] = rssi;
            if (int'(rssi) > high[idx]) high[idx] = rssi;
            sum[idx] += rssi;
            hits[idx]++;
          end
        end
        ACT_SET_POS: begin
          cx[idx] = x;
          cy[idx] = y;
        end
        ACT_REPORT: results_due.push_back(report_of(idx));
        default: results_due.push_back(locate_now());
      endcase
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(res_t got);
      res_t e;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = results_due.pop_front();
      field("kind", e.kind, got.kind);
      field("avg_rssi", e.avg_rssi, got.avg_rssi);
      field("min_rssi", e.min_rssi, got.min_rssi);
      field("max_rssi", e.max_rssi, got.max_rssi);
      field("avg_interval_ms", e.avg_interval_ms, got.avg_interval_ms);
      field("sighting_count", e.sighting_count, got.sighting_count);
      field("est_x", e.est_x, got.est_x);
      field("est_y", e.est_y, got.est_y);
      field("neighbours_used", e.neighbours_used, got.neighbours_used);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [5:0]  cfg_wdata_i;
  logic        push;
  logic        full;
  logic [1:0]  action_i;
  logic [5:0]  tag_index_i;
  logic [7:0]  rssi_i;
  logic [26:0] time_ms_i;
  logic [7:0]  pos_x_i;
  logic [7:0]  pos_y_i;
  logic        empty;
  logic        pop;
  res_t        got;

  locator_scoreboard tally;
  int  idle_cycles;
  int  stall_left;
  bit  rx_eager;     // when set, the result side never stalls
  bit  tx_eager;     // when set, the request side never idles
  int unsigned now_ms;

  rssi_tag_stats_knn_locator i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .action_i         (action_i),
    .tag_index_i      (tag_index_i),
    .rssi_i           (rssi_i),
    .time_ms_i        (time_ms_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .empty            (empty),
    .pop              (pop),
    .kind_o           (got.kind),
    .avg_rssi_o       (got.avg_rssi),
    .min_rssi_o       (got.min_rssi),
    .max_rssi_o       (got.max_rssi),
    .avg_interval_ms_o(got.avg_interval_ms),
    .sighting_count_o (got.sighting_count),
    .est_x_o          (got.est_x),
    .est_y_o          (got.est_y),
    .neighbours_used_o(got.neighbours_used)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Pick a gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result side: stall at random, drop pop during stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (rx_eager) begin
      pop <= 1'b1;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
    end
  end

  // Sample between edges: a result counts as taken at the coming rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) tally.check(got);
      if ((pop && !empty) || (push && !full)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("rssi_tag_stats_knn_locator: mismatch");
        $finish;
      end
    end
  end

  // Issue one request and hold it until it is taken. Called at a rising edge.
  task automatic send(action_e act, logic [5:0] idx, logic [7:0] rssi,
                      logic [26:0] t, logic [7:0] x, logic [7:0] y);
    int g;
    g = tx_eager ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push        <= 1'b1;
    action_i    <= act;
    tag_index_i <= idx;
    rssi_i      <= rssi;
    time_ms_i   <= t;
    pos_x_i     <= x;
    pos_y_i     <= y;
    do @(negedge clk_i); while (full);
    @(posedge clk_i);
    tally.note(act, idx, rssi, t, x, y);
  endtask

  // Hold off requests until every result has come and the queue has drained.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (tally.results_due.size() != 0);
    repeat (80) @(posedge clk_i);
  endtask

  // Pulse the write enable for one edge, then drop it before returning.
  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tally.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Advance the clock of sightings; jump anywhere now and then.
  function automatic logic [26:0] next_ms();
    if ($urandom_range(0, 49) == 0) now_ms = $urandom_range(0, MAX_TIME);
    else now_ms = now_ms + $urandom_range(0, 3000);
    if (now_ms > MAX_TIME) now_ms = MAX_TIME;
    return now_ms;
  endfunction

  task automatic random_phase(int n, int locate_pct);
    int p;
    action_e act;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < locate_pct) act = ACT_LOCATE;
      else if (p < 55) act = ACT_OBSERVE;
      else if (p < 72) act = ACT_SET_POS;
      else act = ACT_REPORT;
      send(act, $urandom_range(0, NTAG - 1), $urandom_range(0, 255), next_ms(),
           $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    tally = new();
    idle_cycles = 0;
    rx_eager = 1'b0;
    tx_eager = 1'b0;
    now_ms = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_NEIGHBOUR_COUNT;
    cfg_wdata_i = '0;
    push = 1'b0;
    action_i = ACT_OBSERVE;
    tag_index_i = '0;
    rssi_i = '0;
    time_ms_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unseen entries, lone target, extremes, time going backwards.
    send(ACT_REPORT, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_LOCATE, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd0, 8'h80, 27'd0, 8'd0, 8'd0);
    send(ACT_LOCATE, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd63, 8'h7f, MAX_TIME, 8'd0, 8'd0);
    send(ACT_SET_POS, 6'd63, 8'h00, 27'd0, 8'd255, 8'd255);
    send(ACT_SET_POS, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd1, 8'hd5, 27'd70000000, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd1, 8'h2a, 27'd1000, 8'd0, 8'd0);
    send(ACT_SET_POS, 6'd1, 8'h00, 27'd0, 8'haa, 8'h55);
    send(ACT_OBSERVE, 6'd2, 8'h55, 27'd2000, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd2, 8'haa, 27'h5555555, 8'd0, 8'd0);
    send(ACT_OBSERVE, 6'd2, 8'h00, 27'h7ffffff & MAX_TIME, 8'd0, 8'd0);
    send(ACT_SET_POS, 6'd2, 8'h00, 27'd0, 8'h55, 8'haa);
    send(ACT_REPORT, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_REPORT, 6'd1, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_REPORT, 6'd2, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_REPORT, 6'd63, 8'h00, 27'd0, 8'd0, 8'd0);
    send(ACT_LOCATE, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    drain();

    // Zero neighbours, then the largest count, against the last tag.
    write_reg(REG_NEIGHBOUR_COUNT, 6'd0);
    write_reg(REG_TARGET_TAG, 6'd63);
    send(ACT_LOCATE, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    drain();
    write_reg(REG_NEIGHBOUR_COUNT, 6'd63);
    send(ACT_LOCATE, 6'd0, 8'h00, 27'd0, 8'd0, 8'd0);
    drain();

    // Back-to-back observes of one entry at full rate, extremes of RSSI.
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    for (int k = 0; k < 20; k++)
      send(ACT_OBSERVE, 6'd9, (k % 3 == 0) ? 8'h80 : 8'h7f, next_ms(), 8'd0, 8'd0);
    send(ACT_REPORT, 6'd9, 8'h00, 27'd0, 8'd0, 8'd0);
    random_phase(150, 4);
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    drain();

    write_reg(REG_NEIGHBOUR_COUNT, 6'd1);
    write_reg(REG_TARGET_TAG, 6'd9);
    random_phase(450, 10);
    drain();
    write_reg(REG_NEIGHBOUR_COUNT, 6'd63);
    write_reg(REG_TARGET_TAG, $urandom_range(0, 63));
    random_phase(300, 2);
    drain();
    write_reg(REG_NEIGHBOUR_COUNT, $urandom_range(1, 62));
    write_reg(REG_TARGET_TAG, $urandom_range(0, 63));
    random_phase(400, 10);
    drain();
    write_reg(REG_NEIGHBOUR_COUNT, 6'd4);
    write_reg(REG_TARGET_TAG, 6'd0);
    random_phase(450, 10);

    drain();
    if (tally.errors == 0) begin
      $display("rssi_tag_stats_knn_locator: match");
    end else begin
      $display("rssi_tag_stats_knn_locator: mismatch");
    end
    $finish;
  end

endmodule
